@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps

package ple_pkg;

  // Default list capacity; the top level takes it as a parameter.
  localparam int CAPACITY_DEF = 32;

  // Field widths of the channels.
  localparam int ACT_W = 2;
  localparam int POS_W = 16;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int IDX_W = 5;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_HEAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INS  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEL  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TRAV = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_TAIL  = 3'd1;
  localparam logic [ST_W-1:0] ST_BOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

  // What an accepted word will do to the list.
  typedef enum logic [2:0] {
    PLAN_NONE = 3'd0,
    PLAN_PUT  = 3'd1,
    PLAN_UP   = 3'd2,
    PLAN_DN   = 3'd3,
    PLAN_DEC  = 3'd4,
    PLAN_TRAV = 3'd5
  } plan_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic step;
    logic put;
    logic dec;
    logic load_resp;
    logic load_entry;
  } ple_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    plan_t plan;
    logic  rem_zero;
  } ple_stat_t;

endpackage

@@ rtl/ple_in_if.sv @@
`timescale 1ns / 1ps

interface ple_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ple_pkg::ACT_W-1:0]    action;
  logic signed [ple_pkg::POS_W-1:0]    position;
  logic signed [ple_pkg::VAL_W-1:0]    value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

@@ rtl/ple_out_if.sv @@
`timescale 1ns / 1ps

interface ple_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ple_pkg::ST_W-1:0]     status;
  logic        [ple_pkg::IDX_W-1:0]    entry_index;
  logic signed [ple_pkg::VAL_W-1:0]    entry_value;
  logic                                last;

  modport source (output valid, status, entry_index, entry_value, last, input ready);
  modport sink   (input valid, status, entry_index, entry_value, last, output ready);
endinterface

@@ rtl/positional_list_engine.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Word contents
// in_chan   input      valid / ready  action, position, value
// out_chan  output     valid / ready  status, entry_index, entry_value, last
//
// One word at a time. A head insert into a non-empty list, an insert at
// p < count and a delete of a non-final entry move the later entries one
// place per cycle through the store's single write port; a traverse reads
// the entries one by one (registered read). Reset empties the list but
// never clears the store. A stalled result word holds until taken, and no
// new word is accepted meanwhile.

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input logic             clk,
  input logic             rst_n,
  ple_in_if.sink          in_chan,
  ple_out_if.source       out_chan
);

  // Commands and status between the controller and the datapath.
  ple_pkg::ple_cmd_t  cmd;
  ple_pkg::ple_stat_t stat;

  // The controller sequences each word: it captures the input word, lets the
  // datapath decide what the word does to the list, runs the shift walk or the
  // traverse, and presents each result word until it is taken.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the entry count, the captured word, the walk pointer,
  // the entry store and the result register that drives the output channel.
  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_chan.action),
    .in_position     (in_chan.position),
    .in_value        (in_chan.value),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_chan.status),
    .out_entry_index (out_chan.entry_index),
    .out_entry_value (out_chan.entry_value),
    .out_last        (out_chan.last)
  );

endmodule

@@ rtl/ple_ram.sv @@
`timescale 1ns / 1ps

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ple_datapath.sv @@
`timescale 1ns / 1ps

module ple_datapath #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic        [ple_pkg::ACT_W-1:0] in_action,
  input  logic signed [ple_pkg::POS_W-1:0] in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_value,
  input  ple_pkg::ple_cmd_t                cmd,
  output ple_pkg::ple_stat_t               stat,
  output logic        [ple_pkg::ST_W-1:0]  out_status,
  output logic        [ple_pkg::IDX_W-1:0] out_entry_index,
  output logic signed [ple_pkg::VAL_W-1:0] out_entry_value,
  output logic                             out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Captured word.
  logic        [ple_pkg::ACT_W-1:0] act_r;
  logic signed [ple_pkg::POS_W-1:0] pos_r;
  logic signed [ple_pkg::VAL_W-1:0] val_r;

  // List length and walk state.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] pend_addr_r;
  logic          pend_r;
  logic          walk_up_r;
  logic          walk_wr_r;
  logic [ple_pkg::ST_W-1:0] code_r;

  // Decision logic.
  logic [ple_pkg::POS_W-1:0] pos16, cnt16;
  logic                      neg, beyond, full, empty, del_mid;
  ple_pkg::plan_t            plan;
  logic [ple_pkg::ST_W-1:0]  code;
  logic [AW-1:0]             ins_pos;

  // Memory port.
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ple_pkg::VAL_W-1:0]  wr_data;
  logic [ple_pkg::VAL_W-1:0]  rd_data;
  logic [15:0]                idx_ext;

  assign pos16   = {1'b0, pos_r[ple_pkg::POS_W-2:0]};
  assign cnt16   = 16'(cnt_r);
  assign neg     = pos_r[ple_pkg::POS_W-1];
  assign beyond  = pos16 >= cnt16;
  assign full    = cnt_r == CW'(CAPACITY);
  assign empty   = cnt_r == '0;
  assign del_mid = (pos16 + 16'd1) < cnt16;

  always_comb begin
    plan = ple_pkg::PLAN_NONE;
    code = ple_pkg::ST_OK;
    case (act_r)
      ple_pkg::ACT_HEAD: begin
        if (full) begin
          code = ple_pkg::ST_FULL;
        end else if (empty) begin
          plan = ple_pkg::PLAN_PUT;
        end else begin
          plan = ple_pkg::PLAN_UP;
        end
      end
      ple_pkg::ACT_INS: begin
        if (neg) begin
          code = ple_pkg::ST_BOUND;
        end else if (full) begin
          code = ple_pkg::ST_FULL;
        end else if (beyond) begin
          plan = ple_pkg::PLAN_PUT;
          code = ple_pkg::ST_TAIL;
        end else begin
          plan = ple_pkg::PLAN_UP;
        end
      end
      ple_pkg::ACT_DEL: begin
        if (neg || beyond) begin
          code = ple_pkg::ST_BOUND;
        end else if (del_mid) begin
          plan = ple_pkg::PLAN_DN;
        end else begin
          plan = ple_pkg::PLAN_DEC;
        end
      end
      default: begin
        if (empty) begin
          code = ple_pkg::ST_EMPTY;
        end else begin
          plan = ple_pkg::PLAN_TRAV;
        end
      end
    endcase
  end

  // Head insert goes to the front, an append to the tail, otherwise to the position.
  always_comb begin
    if (act_r == ple_pkg::ACT_HEAD) begin
      ins_pos = '0;
    end else if (beyond) begin
      ins_pos = cnt_r[AW-1:0];
    end else begin
      ins_pos = pos_r[AW-1:0];
    end
  end

  assign stat.plan     = plan;
  assign stat.rem_zero = (rem_r == '0);

  always_comb begin
    ptr_nxt = ptr_r;
    rem_nxt = rem_r;
    if (cmd.decide) begin
      case (plan)
        ple_pkg::PLAN_UP: begin
          ptr_nxt = AW'(cnt_r - CW'(1));
          rem_nxt = cnt_r - CW'(ins_pos);
        end
        ple_pkg::PLAN_DN: begin
          ptr_nxt = pos_r[AW-1:0] + AW'(1);
          rem_nxt = cnt_r - CW'(pos_r[AW-1:0]) - CW'(1);
        end
        ple_pkg::PLAN_TRAV: begin
          ptr_nxt = '0;
          rem_nxt = cnt_r;
        end
        default: begin
          rem_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      ptr_nxt = walk_up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
      rem_nxt = rem_r - CW'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.put) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // A word read during a shift is written back one place up or down in the next cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ins_pos;
    wr_data = val_r;
    if (cmd.put) begin
      wr_en = 1'b1;
    end else if (pend_r && walk_wr_r) begin
      wr_en   = 1'b1;
      wr_addr = walk_up_r ? pend_addr_r + AW'(1) : pend_addr_r - AW'(1);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    rem_r <= rem_nxt;
    if (cmd.capture) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.decide) begin
      code_r    <= code;
      walk_up_r <= (plan == ple_pkg::PLAN_UP);
      walk_wr_r <= (plan == ple_pkg::PLAN_UP) || (plan == ple_pkg::PLAN_DN);
    end
    if (cmd.step) begin
      pend_addr_r <= ptr_r;
    end
  end

  assign idx_ext = 16'(pend_addr_r);

  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      out_status      <= code_r;
      out_entry_index <= '0;
      out_entry_value <= '0;
      out_last        <= 1'b1;
    end else if (cmd.load_entry) begin
      out_status      <= ple_pkg::ST_OK;
      out_entry_index <= idx_ext[ple_pkg::IDX_W-1:0];
      out_entry_value <= rd_data;
      out_last        <= (rem_r == '0);
    end
  end

  ple_ram #(
    .WIDTH (ple_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.step),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

endmodule

@@ rtl/ple_ctrl.sv @@
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_FIN    = 8'b0000_1000,
    S_RESP   = 8'b0001_0000,
    S_TRD    = 8'b0010_0000,
    S_TLD    = 8'b0100_0000,
    S_TOUT   = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  ple_pkg::plan_t plan_r, plan_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP) || (state_r == S_TOUT);

  always_comb begin
    state_nxt = state_r;
    plan_nxt  = plan_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        plan_nxt   = stat.plan;
        case (stat.plan)
          ple_pkg::PLAN_UP, ple_pkg::PLAN_DN: state_nxt = S_WALK;
          ple_pkg::PLAN_TRAV:                 state_nxt = S_TRD;
          default:                            state_nxt = S_FIN;
        endcase
      end
      S_WALK: begin
        if (stat.rem_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.load_resp = 1'b1;
        cmd.put       = plan_r inside {ple_pkg::PLAN_PUT, ple_pkg::PLAN_UP};
        cmd.dec       = plan_r inside {ple_pkg::PLAN_DN, ple_pkg::PLAN_DEC};
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_TRD: begin
        cmd.step  = 1'b1;
        state_nxt = S_TLD;
      end
      S_TLD: begin
        cmd.load_entry = 1'b1;
        state_nxt      = S_TOUT;
      end
      S_TOUT: begin
        if (out_ready) begin
          state_nxt = stat.rem_zero ? S_IDLE : S_TRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plan_r  <= ple_pkg::PLAN_NONE;
    end else begin
      state_r <= state_nxt;
      plan_r  <= plan_nxt;
    end
  end

endmodule

@@ test/ple_list_checker.sv @@
`timescale 1ns / 1ps

module ple_list_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ple_in_if    in_mon,
  ple_out_if   out_mon,
  input  logic wrap_up,
  output int   pending,
  output int   fail_count
);

  import ple_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } list_word_t;

  // Shadow copy of the list, position 0 at the front.
  logic signed [VAL_W-1:0] list_entries[$];
  list_word_t              expected_words[$];
  list_word_t              want;
  int                      mismatches = 0;
  bit                      wrapped = 1'b0;

  function automatic list_word_t status_word(logic [ST_W-1:0] st);
    list_word_t w;
    w        = '0;
    w.status = st;
    w.last   = 1'b1;
    return w;
  endfunction

  // Updates the shadow list for one accepted word and queues its results.
  function automatic void apply_word(logic [ACT_W-1:0] act,
                                     logic signed [POS_W-1:0] pos,
                                     logic signed [VAL_W-1:0] val);
    int         slot;
    int         i;
    list_word_t w;
    slot = int'(pos);
    case (act)
      ACT_HEAD: begin
        if (list_entries.size() >= CAPACITY) begin
          expected_words.push_back(status_word(ST_FULL));
        end else begin
          list_entries.push_front(val);
          expected_words.push_back(status_word(ST_OK));
        end
      end
      ACT_INS: begin
        // The sign check takes priority over the full check.
        if (slot < 0) begin
          expected_words.push_back(status_word(ST_BOUND));
        end else if (list_entries.size() >= CAPACITY) begin
          expected_words.push_back(status_word(ST_FULL));
        end else if (slot >= list_entries.size()) begin
          list_entries.push_back(val);
          expected_words.push_back(status_word(ST_TAIL));
        end else begin
          list_entries.insert(slot, val);
          expected_words.push_back(status_word(ST_OK));
        end
      end
      ACT_DEL: begin
        if (slot < 0 || slot >= list_entries.size()) begin
          expected_words.push_back(status_word(ST_BOUND));
        end else begin
          list_entries.delete(slot);
          expected_words.push_back(status_word(ST_OK));
        end
      end
      default: begin
        if (list_entries.size() == 0) begin
          expected_words.push_back(status_word(ST_EMPTY));
        end else begin
          for (i = 0; i < list_entries.size(); i++) begin
            w             = '0;
            w.status      = ST_OK;
            w.entry_index = i[IDX_W-1:0];
            w.entry_value = list_entries[i];
            w.last        = (i == list_entries.size() - 1);
            expected_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        apply_word(in_mon.action, in_mon.position, in_mon.value);
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d index %0d value %0d last %0b",
                 out_mon.status, out_mon.entry_index, out_mon.entry_value, out_mon.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            mismatches++;
          end
          if (out_mon.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index,
                   out_mon.entry_index);
            mismatches++;
          end
          if (out_mon.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, got %0d", want.entry_value,
                   out_mon.entry_value);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (expected_words.size() != 0) begin
          $error("%0d expected result words never arrived", expected_words.size());
          mismatches++;
        end
      end
    end
    pending    <= expected_words.size();
    fail_count <= mismatches;
  end

endmodule

@@ test/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps

// Top of the list engine bench. This module only makes stimulus and gives the
// verdict; the checker beside the engine keeps its own copy of the list,
// predicts every result word and compares them as they leave the engine.

module tb_positional_list_engine;

  import ple_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int N_WORDS      = 330;
  localparam int EPISODE_LEN  = 50;
  localparam int HOLD_START   = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  // The random part runs in episodes: one that mostly inserts, so that the
  // list fills up and the full case is reached, one that mostly deletes, and
  // one with no bias at all.
  typedef enum int {
    EP_GROW   = 0,
    EP_SHRINK = 1,
    EP_MIXED  = 2
  } episode_t;

  logic clk;
  logic rst_n;
  logic wrap_up;
  int   pending;
  int   fail_count;
  int   words_sent = 0;

  ple_in_if  in_chan ();
  ple_out_if out_chan ();

  positional_list_engine #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ple_list_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .wrap_up    (wrap_up),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // About one gap in eight is drawn from the long range, the rest from the short one.
  function automatic int pick_gap();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Positions are mostly within or just past the capacity, with the odd negative
  // or far positive one so that every bit of the field toggles.
  function automatic logic signed [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return {1'b1, 15'($urandom)};
    end
    if (r == 1) begin
      return {1'b0, 15'($urandom)};
    end
    return POS_W'($urandom_range(0, CAPACITY + 4));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word and returns at the edge at which the engine takes it.
  // Valid is left high, so back-to-back words need no idle gap between them.
  task automatic send_word(input logic [ACT_W-1:0] act,
                           input logic signed [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    in_chan.valid    <= 1'b1;
    in_chan.action   <= act;
    in_chan.position <= pos;
    in_chan.value    <= val;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The result side. Ready is decided once per cycle, and once in the run it
  // is held low for a long stretch while the sender keeps offering words, so
  // that the engine backs up and stops taking input.
  initial begin : result_sink
    int rx_cycle;
    int stall;
    bit rx_calm;
    rx_cycle = 0;
    stall    = 0;
    rx_calm  = 1'b0;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      rx_cycle++;
      if (rx_cycle == HOLD_START) begin
        stall = HOLD_CYCLES;
      end
      // Now and then a stretch with no stalls at all.
      if (rx_cycle % 256 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 5) == 0) begin
          stall = pick_gap();
        end
      end
      @(posedge clk);
    end
  end

  // A hung engine or a lost word ends the run here.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_positional_list_engine failed");
    $finish;
  end

  initial begin : word_source
    int                      k;
    int                      ep;
    int                      r;
    bit                      tx_calm;
    episode_t                kind;
    logic [ACT_W-1:0]        act;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;

    rst_n            <= 1'b0;
    wrap_up          <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.action   <= ACT_HEAD;
    in_chan.position <= '0;
    in_chan.value    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Empty list first: a traverse gives the empty status and
    // a delete is out of bounds.
    send_word(ACT_TRAV, 16'sh1234, $urandom);
    send_word(ACT_DEL, 16'sd0, $urandom);
    // Negative insert positions are refused, the most negative one included.
    send_word(ACT_INS, -16'sd1, 32'sd7);
    send_word(ACT_INS, 16'sh8000, 32'sd7);
    // An insert at the end of an empty list appends at the tail.
    send_word(ACT_INS, 16'sd0, 32'sd1);
    // Head inserts ignore the position, so it carries its extremes here.
    send_word(ACT_HEAD, 16'sh8000, 32'sh7fff_ffff);
    send_word(ACT_HEAD, 16'sh7fff, 32'sh8000_0000);
    // Far past the end appends, a position in the middle shifts entries up,
    // and a position exactly at the end appends as well.
    send_word(ACT_INS, 16'sh7fff, -32'sd1);
    send_word(ACT_INS, 16'sd1, 32'shffff_0000);
    send_word(ACT_INS, 16'sd5, 32'sh5555_aaaa);
    send_word(ACT_TRAV, 16'sh0000, 32'sh0);
    // Deletes out of bounds: negative, far positive and exactly at the end.
    send_word(ACT_DEL, -16'sd1, $urandom);
    send_word(ACT_DEL, 16'sh8000, $urandom);
    send_word(ACT_DEL, 16'sh7fff, $urandom);
    send_word(ACT_DEL, 16'sd6, $urandom);
    // Deletes of the last, the first and a middle entry.
    send_word(ACT_DEL, 16'sd5, $urandom);
    send_word(ACT_DEL, 16'sd0, $urandom);
    send_word(ACT_DEL, 16'sd1, $urandom);
    send_word(ACT_TRAV, 16'shffff, 32'shffff_ffff);
    // Empty the list again and traverse it.
    send_word(ACT_DEL, 16'sd0, $urandom);
    send_word(ACT_DEL, 16'sd0, $urandom);
    send_word(ACT_DEL, 16'sd0, $urandom);
    send_word(ACT_TRAV, 16'sh5a5a, $urandom);
    idle_sender(pick_gap());

    // Random part, in episodes. A grow episode comes first so that the list
    // is filled to capacity early and inserts then report full.
    ep = 0;
    while (words_sent < N_WORDS) begin
      kind    = episode_t'(ep % 3);
      tx_calm = ($urandom_range(0, 2) == 0);
      for (k = 0; k < EPISODE_LEN && words_sent < N_WORDS; k++) begin
        r   = $urandom_range(0, 19);
        pos = $urandom;
        val = pick_value();
        case (kind)
          EP_GROW: begin
            if (r < 7) begin
              act = ACT_HEAD;
            end else if (r < 15) begin
              act = ACT_INS;
              pos = POS_W'($urandom_range(0, CAPACITY + 4));
            end else if (r == 15) begin
              act = ACT_INS;
              pos = pick_position();
            end else if (r == 16) begin
              // A negative position must win over a full list.
              act = ACT_INS;
              pos = {1'b1, 15'($urandom)};
            end else if (r == 17) begin
              act = ACT_DEL;
              pos = pick_position();
            end else begin
              act = ACT_TRAV;
            end
          end
          EP_SHRINK: begin
            if (r < 13) begin
              act = ACT_DEL;
              pos = POS_W'($urandom_range(0, $urandom_range(0, CAPACITY + 1)));
            end else if (r == 13) begin
              act = ACT_DEL;
              pos = pick_position();
            end else if (r < 16) begin
              act = ACT_TRAV;
            end else begin
              act = ($urandom_range(0, 1) == 0) ? ACT_HEAD : ACT_INS;
              pos = pick_position();
            end
          end
          default: begin
            act = ACT_W'($urandom_range(0, 3));
            pos = pick_position();
          end
        endcase
        send_word(act, pos, val);
        if (!tx_calm && $urandom_range(0, 3) == 0) begin
          idle_sender(pick_gap());
        end
      end
      ep++;
    end
    in_chan.valid <= 1'b0;

    // The checker's count of outstanding words is registered, so let it update
    // before looking, then let the engine settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_positional_list_engine passed");
    end else begin
      $display("tb_positional_list_engine failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ple_pkg.sv
rtl/ple_in_if.sv
rtl/ple_out_if.sv
rtl/ple_ram.sv
rtl/ple_datapath.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
test/ple_list_checker.sv
test/tb_positional_list_engine.sv
